FILE: sv/telnet_option_negotiator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the telnet option negotiator.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_UNIT_ASSERT_SVH
`define TELNET_OPTION_NEGOTIATOR_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TON_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ton check failed: lbl");

// A condition that must hold in the cycle after the trigger holds.
`define TON_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("ton check failed: lbl");

`endif

FILE: sv/ton_pkg.sv
// ----------------------------------------------------------------------------
// ton_pkg
// Types and constants shared by the telnet option negotiator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ton_pkg;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_GA   = 8'd249;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_EOR  = 8'd239;

    // Telnet option codes
    localparam logic [7:0] O_BINARY    = 8'd0;
    localparam logic [7:0] O_ECHO      = 8'd1;
    localparam logic [7:0] O_SGA       = 8'd3;
    localparam logic [7:0] O_TTYPE     = 8'd24;
    localparam logic [7:0] O_EOR       = 8'd25;
    localparam logic [7:0] O_NAWS      = 8'd31;
    localparam logic [7:0] O_LINEMODE  = 8'd34;
    localparam logic [7:0] O_COMPRESS2 = 8'd86;
    localparam logic [7:0] O_COMPRESS4 = 8'd88;
    localparam logic [7:0] O_MPLEX     = 8'h70;
    localparam logic [7:0] O_GMCP      = 8'd201;
    localparam logic [7:0] O_NONE      = 8'd0;

    // Parser position within an IAC sequence
    typedef enum logic [2:0] {
        PM_NORMAL = 3'd0,
        PM_IAC    = 3'd1,
        PM_SB     = 3'd2,
        PM_WILL   = 3'd3,
        PM_WONT   = 3'd4,
        PM_DO     = 3'd5,
        PM_DONT   = 3'd6
    } parse_mode_t;

    // Result kinds
    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_PAYLOAD = 3'd1,
        K_SEEND   = 3'd2,
        K_PROMPT  = 3'd3,
        K_REPLY   = 3'd4,
        K_WINSIZE = 3'd5
    } kind_t;

    // Negotiation state carried from byte to byte
    typedef struct packed {
        parse_mode_t parse_mode;
        logic [7:0]  subneg_option;
        logic        eor_agreed;
        logic        echo_flag;
        logic        charmode_flag;
        logic        naws_agreed;
        logic        ttype_agreed;
        logic        gmcp_flag;
    } neg_state_t;

    // One result item as presented downstream
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [7:0] option;
        logic       last;
        logic       echo_on;
        logic       char_mode;
    } result_t;

    // Up to two results caused by one byte, pushed into the result queue
    typedef struct packed {
        logic [1:0] num;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

FILE: sv/ton_decode.sv
// ----------------------------------------------------------------------------
// ton_decode
// Combinational decode of one received byte against the negotiation state.
// ----------------------------------------------------------------------------
`default_nettype none

module ton_decode (
    input  ton_pkg::neg_state_t st,
    input  logic [7:0]          rx_data,
    output ton_pkg::neg_state_t st_next,
    output ton_pkg::push_t      push
);
    import ton_pkg::*;

    neg_state_t nxt;
    result_t    r0;
    result_t    r1;
    logic [1:0] num;

    // Byte-level parser and option policy
    always_comb
    begin
        nxt            = st;
        nxt.parse_mode = PM_NORMAL;
        num            = 2'd0;
        r0             = '0;
        r1             = '0;

        case (st.parse_mode)
            PM_IAC:
            begin
                if (rx_data == B_EOR || rx_data == B_GA)
                begin
                    nxt.eor_agreed = 1'b1;
                    num      = 2'd1;
                    r0.kind  = K_PROMPT;
                    r0.value = rx_data;
                end
                else if (rx_data == B_IAC)
                begin
                    // Escaped 255 is passed on as an ordinary byte.
                    num      = 2'd1;
                    r0.value = B_IAC;
                    if (st.subneg_option != O_NONE)
                    begin
                        r0.kind   = K_PAYLOAD;
                        r0.option = st.subneg_option;
                    end
                    else
                    begin
                        r0.kind = K_DATA;
                    end
                end
                else if (rx_data == B_WILL)
                begin
                    nxt.parse_mode = PM_WILL;
                end
                else if (rx_data == B_WONT)
                begin
                    nxt.parse_mode = PM_WONT;
                end
                else if (rx_data == B_DO)
                begin
                    nxt.parse_mode = PM_DO;
                end
                else if (rx_data == B_DONT)
                begin
                    nxt.parse_mode = PM_DONT;
                end
                else if (rx_data == B_SB)
                begin
                    nxt.parse_mode = PM_SB;
                end
                else if (rx_data == B_SE)
                begin
                    num               = 2'd1;
                    r0.kind           = K_SEEND;
                    r0.option         = st.subneg_option;
                    nxt.subneg_option = O_NONE;
                end
            end

            PM_SB:
            begin
                nxt.subneg_option = rx_data;
            end

            PM_WILL:
            begin
                r0.kind   = K_REPLY;
                r0.option = rx_data;
                r0.value  = B_DO;
                num       = 2'd1;
                if (rx_data == O_ECHO)
                begin
                    nxt.echo_flag = 1'b1;
                end
                else if (rx_data == O_GMCP)
                begin
                    nxt.gmcp_flag = 1'b1;
                end
                else if (rx_data == O_EOR)
                begin
                    // Agreed only once; a repeat gets no answer.
                    if (st.eor_agreed)
                    begin
                        num = 2'd0;
                    end
                    nxt.eor_agreed = 1'b1;
                end
                else if (rx_data == O_SGA)
                begin
                    nxt.charmode_flag = 1'b1;
                end
                else if (rx_data == O_MPLEX || rx_data == O_COMPRESS4 ||
                         rx_data == O_COMPRESS2 || rx_data == O_BINARY)
                begin
                    r0.value = B_DO;
                end
                else
                begin
                    r0.value = B_DONT;
                end
            end

            PM_WONT:
            begin
                if (rx_data == O_ECHO)
                begin
                    nxt.echo_flag = 1'b0;
                    num       = 2'd1;
                    r0.kind   = K_REPLY;
                    r0.value  = B_DONT;
                    r0.option = rx_data;
                end
            end

            PM_DO:
            begin
                if (rx_data == O_LINEMODE)
                begin
                    nxt.charmode_flag = 1'b0;
                end
                r0.kind   = K_REPLY;
                r0.option = rx_data;
                r0.value  = B_WILL;
                num       = 2'd1;
                if (rx_data == O_SGA || rx_data == O_BINARY)
                begin
                    r0.value = B_WILL;
                end
                else if (rx_data == O_NAWS)
                begin
                    // First agreement also asks for a window-size report.
                    if (st.naws_agreed)
                    begin
                        num = 2'd0;
                    end
                    else
                    begin
                        num       = 2'd2;
                        r1.kind   = K_WINSIZE;
                        r1.option = O_NAWS;
                    end
                    nxt.naws_agreed = 1'b1;
                end
                else if (rx_data == O_TTYPE)
                begin
                    if (st.ttype_agreed)
                    begin
                        num = 2'd0;
                    end
                    nxt.ttype_agreed = 1'b1;
                end
                else
                begin
                    r0.value = B_WONT;
                end
            end

            PM_DONT:
            begin
                nxt.parse_mode = PM_NORMAL;
            end

            default:
            begin
                if (rx_data == B_IAC)
                begin
                    nxt.parse_mode = PM_IAC;
                end
                else
                begin
                    num      = 2'd1;
                    r0.value = rx_data;
                    if (st.subneg_option != O_NONE)
                    begin
                        r0.kind   = K_PAYLOAD;
                        r0.option = st.subneg_option;
                    end
                    else
                    begin
                        r0.kind = K_DATA;
                    end
                end
            end
        endcase

        // Flags shown with each result are those after this byte.
        r0.echo_on   = nxt.echo_flag;
        r0.char_mode = nxt.charmode_flag;
        r1.echo_on   = nxt.echo_flag;
        r1.char_mode = nxt.charmode_flag;
        r0.last      = (num == 2'd1);
        r1.last      = 1'b1;
    end

    assign st_next   = nxt;
    assign push.num  = num;
    assign push.res0 = r0;
    assign push.res1 = r1;

endmodule

`default_nettype wire

FILE: sv/ton_result_queue.sv
// ----------------------------------------------------------------------------
// ton_result_queue
// Four-entry result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module ton_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  ton_pkg::push_t   push,
    output logic             room,
    output logic             head_valid,
    output ton_pkg::result_t head,
    input  logic             pop
);
    import ton_pkg::*;

    localparam int Depth = 4;

    result_t    entry_reg [Depth];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] push_num;
    logic       do_pop;

    // Room for a worst-case pair of results, judged on the current fill.
    assign room       = (count_reg <= 3'd2);
    assign head_valid = (count_reg != 3'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign push_num   = push_en ? push.num : 2'd0;

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_num;
        rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
        count_next  = count_reg + {1'b0, push_num} - {2'b00, do_pop};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push_num == 2'd2)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= push.res1;
        end
    end

endmodule

`default_nettype wire

FILE: sv/telnet_option_negotiator_unit.sv
// ----------------------------------------------------------------------------
// telnet_option_negotiator_unit
// Receive-side telnet IAC parser and option negotiator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one received byte (rx_byte) per
//   transaction. Output channel: out_valid / out_stall carry one result
//   (kind, value, option, last, echo_on, char_mode) per transaction.
//   Each byte gives zero, one or two results; last marks the final one.
//   An accepted byte waits in the input register and is decoded there;
//   once at least two entries of the four-entry result queue are free,
//   its results enter the queue and are offered from its head.
//   Throughput: one byte per cycle while in_stall is low; the output port
//   delivers one result per cycle while out_stall is low, so a byte that
//   yields two results (first DO NAWS) sends them out one after the other.
//   Reset clears the parser to normal data mode, closes any subnegotiation,
//   clears all agreement flags and empties the queue.
//   When the receiver stalls, results wait in the queue; once fewer than two
//   entries are free the input register holds and in_stall rises until space
//   returns.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_option_negotiator_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] value,
    output logic [7:0] option,
    output logic       last,
    output logic       echo_on,
    output logic       char_mode
);
    import ton_pkg::*;

    logic       byte_valid_reg;
    logic       byte_valid_next;
    logic [7:0] byte_reg;
    neg_state_t state_reg;
    neg_state_t state_next;
    push_t      push;
    result_t    head;
    logic       room;
    logic       consume;
    logic       accept_in;

    // Input register handshake
    assign consume   = byte_valid_reg && room;
    assign in_stall  = byte_valid_reg && !room;
    assign accept_in = in_valid && !in_stall;
    assign byte_valid_next = accept_in || (byte_valid_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Byte decode
    ton_decode u_decode (
        .st      (state_reg),
        .rx_data (byte_reg),
        .st_next (state_next),
        .push    (push)
    );

    // Negotiation state advances only when a byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{parse_mode: PM_NORMAL, subneg_option: O_NONE, default: 1'b0};
        end
        else if (consume)
        begin
            state_reg <= state_next;
        end
    end

    // Result queue and output port
    ton_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (consume),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .head       (head),
        .pop        (!out_stall)
    );

    assign kind      = head.kind;
    assign value     = head.value;
    assign option    = head.option;
    assign last      = head.last;
    assign echo_on   = head.echo_on;
    assign char_mode = head.char_mode;

endmodule

`default_nettype wire

FILE: sv/ton_checker.sv
// ----------------------------------------------------------------------------
// ton_checker
// Port-level checks on the telnet option negotiator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telnet_option_negotiator_unit_assert.svh"

module ton_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [7:0] rx_byte,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [2:0] kind,
    input wire logic [7:0] value,
    input wire logic [7:0] option,
    input wire logic       last,
    input wire logic       echo_on,
    input wire logic       char_mode
);
    import ton_pkg::*;

    logic unused_ok;
    assign unused_ok = in_valid ^ in_stall ^ (^rx_byte) ^ echo_on ^ char_mode;

    // A stalled result stays offered.
    `TON_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)

    // A window-size request is always the closing result and names NAWS.
    `TON_ASSERT_ALWAYS(a_winsize_last, !out_valid || kind != K_WINSIZE || (last && option == O_NAWS))

    // A non-final result is the NAWS reply, and its window-size request follows.
    `TON_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last, out_valid && kind == K_WINSIZE)

    // Plain data carries no option; a reply verb is always WILL to DONT.
    `TON_ASSERT_ALWAYS(a_data_opt, !out_valid || kind != K_DATA || option == O_NONE)
    `TON_ASSERT_ALWAYS(a_reply_verb, !out_valid || kind != K_REPLY || value == B_WILL || value == B_WONT || value == B_DO || value == B_DONT)

endmodule

bind telnet_option_negotiator_unit ton_checker u_ton_checker (.*);

`default_nettype wire
